@@ rtl/rotary_encoder_button_decoder_top_macros.svh @@
// Assertion macros for the rotary encoder and button decoder.
// Expect signals named clk and rst_n in the scope of each use.
`ifndef ROTARY_ENCODER_BUTTON_DECODER_TOP_MACROS_SVH
`define ROTARY_ENCODER_BUTTON_DECODER_TOP_MACROS_SVH

// Check a property on every rising edge, skipping cycles in reset
`define REBD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on every rising edge, reset included
`define REBD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ rtl/rebd_pkg.sv @@
// Package for the rotary encoder and button decoder.
// Holds payload structs, code constants and configuration defaults; no dependencies.
`timescale 1ns / 1ps

package rebd_pkg;

    // Default time width and fixed field widths
    localparam int TIME_WIDTH_DEF = 32;
    localparam int NOW_W          = 32;
    localparam int MS_W           = 16;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERT     = 2'd2;

    // Configuration reset values
    localparam logic [MS_W-1:0] DEBOUNCE_MS_RST   = 16'd200;
    localparam logic [MS_W-1:0] LONG_PRESS_MS_RST = 16'd5000;

    // Rotation counter limits
    localparam logic signed [7:0] CNT_MAX = 8'sd127;
    localparam logic signed [7:0] CNT_MIN = -8'sd127;

    // Operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_POLL   = 1'b1;

    // Poll event codes
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SELECT = 2'd1,
        EV_NEXT   = 2'd2,
        EV_PREV   = 2'd3
    } event_t;

    // Configuration register group
    typedef struct packed {
        logic [MS_W-1:0] debounce_ms;
        logic [MS_W-1:0] long_press_ms;
        logic            invert_direction;
    } cfg_t;

    // One input transaction
    typedef struct packed {
        logic             operation;
        logic             enc_a;
        logic             enc_b;
        logic             button_raw;
        logic [NOW_W-1:0] now_ms;
    } item_t;

    // One result transaction
    typedef struct packed {
        event_t event_code;
        logic   beep;
        logic   soft_reset;
    } result_t;

endpackage

@@ rtl/rebd_if.sv @@
// Handshake channel interfaces for the rotary encoder and button decoder.
// Depends on rebd_pkg for field widths.
`timescale 1ns / 1ps

interface rebd_item_if;
    import rebd_pkg::*;
    logic             valid;
    logic             ready;
    logic             operation;
    logic             enc_a;
    logic             enc_b;
    logic             button_raw;
    logic [NOW_W-1:0] now_ms;

    modport source (output valid, operation, enc_a, enc_b, button_raw, now_ms,
                    input ready);
    modport sink   (input valid, operation, enc_a, enc_b, button_raw, now_ms,
                    output ready);
endinterface

interface rebd_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_code;
    logic       beep;
    logic       soft_reset;

    modport source (output valid, event_code, beep, soft_reset, input ready);
    modport sink   (input valid, event_code, beep, soft_reset, output ready);
endinterface

@@ rtl/rotary_encoder_button_decoder_top.sv @@
// Channel     Dir  Payload                                          Handshake
// item        in   operation, enc_a, enc_b, button_raw, now_ms      valid/ready
// result      out  event_code, beep, soft_reset                     valid/ready
// wr_*        in   wr_index, wr_data                                wr_en, no wait
//
// One transaction per cycle while results are taken; each item is held in the
// input register, its result in the result register, one decode step between them.
// Reset loads debounce 200 ms, long press 5000 ms, no inversion, and clears decoder state.
// A stalled result holds the result register; the input register then fills and
// item.ready drops until the result is taken.
//
// Top level of the rotary encoder and button decoder; depends on rebd_pkg,
// rebd_if, rebd_cfg, rebd_core and the macros header.
`timescale 1ns / 1ps
`include "rotary_encoder_button_decoder_top_macros.svh"

module rotary_encoder_button_decoder_top
    import rebd_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    rebd_item_if.sink              item,
    rebd_result_if.source          result,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result_reg;
    result_t core_res;
    logic    result_valid_reg;
    logic    advance;

    // Move the held item through decode when the result slot frees up
    assign advance    = item_valid_reg && (!result_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;

    rebd_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    rebd_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (core_res)
    );

    // Capture an incoming transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item.valid && item.ready)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg.operation  <= item.operation;
            item_reg.enc_a      <= item.enc_a;
            item_reg.enc_b      <= item.enc_b;
            item_reg.button_raw <= item.button_raw;
            item_reg.now_ms     <= item.now_ms;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= core_res;
        end
    end

    assign result.valid      = result_valid_reg;
    assign result.event_code = result_reg.event_code;
    assign result.beep       = result_reg.beep;
    assign result.soft_reset = result_reg.soft_reset;

    // Check result register fill and field consistency
    `REBD_ASSERT(a_advance_fills_result, advance |=> result_valid_reg, "decoded item lost")
    `REBD_ASSERT_ALWAYS(a_soft_needs_beep,
        result_valid_reg && result_reg.soft_reset |-> result_reg.beep,
        "soft_reset without press")
    `REBD_ASSERT_ALWAYS(a_poll_is_quiet,
        result_valid_reg && result_reg.event_code != EV_NONE
            |-> !result_reg.beep && !result_reg.soft_reset,
        "poll result carries sample flags")

endmodule

@@ rtl/rebd_cfg.sv @@
// Configuration registers of the rotary encoder and button decoder.
// Depends on rebd_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module rebd_cfg
    import rebd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; indexes past the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_DEBOUNCE:   cfg_next.debounce_ms      = wr_data[MS_W-1:0];
                REG_LONG_PRESS: cfg_next.long_press_ms    = wr_data[MS_W-1:0];
                REG_INVERT:     cfg_next.invert_direction = wr_data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the register values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms      <= DEBOUNCE_MS_RST;
            cfg_reg.long_press_ms    <= LONG_PRESS_MS_RST;
            cfg_reg.invert_direction <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/rebd_core.sv @@
// Decode logic and state of the rotary encoder and button decoder.
// Depends on rebd_pkg for item_t, result_t, cfg_t and code constants.
`timescale 1ns / 1ps

module rebd_core
    import rebd_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_HI_HALF  = 3'd1,
        PH_LO_HALF  = 3'd2,
        PH_BOTH_LOW = 3'd3,
        PH_INVALID  = 3'd5
    } phase_t;

    phase_t                 phase_reg,   phase_next;
    logic signed [7:0]      count_reg,   count_next;
    logic                   pending_reg, pending_next;
    logic                   last_reg,    last_next;
    logic [TIME_WIDTH-1:0]  long_reg,    long_next;
    logic [TIME_WIDTH-1:0]  short_reg,   short_next;

    logic                   lo;
    logic                   hi;
    logic                   pressed;
    logic [TIME_WIDTH-1:0]  now;
    logic [TIME_WIDTH-1:0]  long_target;
    logic [TIME_WIDTH-1:0]  short_target;

    // Map pins and time into the decode domain
    assign lo           = cfg.invert_direction ? item.enc_b : item.enc_a;
    assign hi           = cfg.invert_direction ? item.enc_a : item.enc_b;
    assign pressed      = ~item.button_raw;
    assign now          = TIME_WIDTH'(item.now_ms);
    assign long_target  = now + TIME_WIDTH'(cfg.long_press_ms);
    assign short_target = now + TIME_WIDTH'(cfg.debounce_ms);

    // Work out next state and the result for this transaction
    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        pending_next = pending_reg;
        last_next    = last_reg;
        long_next    = long_reg;
        short_next   = short_reg;
        res.event_code = EV_NONE;
        res.beep       = 1'b0;
        res.soft_reset = 1'b0;

        if (item.operation == OP_POLL)
        begin
            // Report the highest priority event and clear it
            if (pending_reg)
            begin
                pending_next   = 1'b0;
                res.event_code = EV_SELECT;
            end
            else if (count_reg > 8'sd0)
            begin
                count_next     = 8'sd0;
                res.event_code = EV_NEXT;
            end
            else if (count_reg < 8'sd0)
            begin
                count_next     = 8'sd0;
                res.event_code = EV_PREV;
            end
        end
        else
        begin
            // Advance the phase tracker; count a detent on both pins low
            if (lo && hi)
            begin
                phase_next = PH_IDLE;
            end
            else if (hi)
            begin
                phase_next = (phase_reg == PH_IDLE || phase_reg == PH_HI_HALF) ?
                             PH_HI_HALF : PH_INVALID;
            end
            else if (lo)
            begin
                phase_next = (phase_reg == PH_IDLE || phase_reg == PH_LO_HALF) ?
                             PH_LO_HALF : PH_INVALID;
            end
            else
            begin
                if (phase_reg == PH_HI_HALF && count_reg < CNT_MAX)
                begin
                    count_next = count_reg + 8'sd1;
                end
                if (phase_reg == PH_LO_HALF && count_reg > CNT_MIN)
                begin
                    count_next = count_reg - 8'sd1;
                end
                phase_next = PH_BOTH_LOW;
            end

            // Fire the long press pulse once, drop the deadline on release
            res.beep = pressed;
            if (pressed)
            begin
                if (long_reg != '0 && long_reg < now)
                begin
                    res.soft_reset = 1'b1;
                    long_next      = '0;
                end
            end
            else
            begin
                long_next = '0;
            end

            // On a button edge arm the long deadline and debounce presses
            if (pressed != last_reg)
            begin
                if (pressed)
                begin
                    long_next = long_target;
                end
                last_next = pressed;
                if (pressed && short_reg < now)
                begin
                    short_next   = short_target;
                    pending_next = 1'b1;
                end
            end
        end
    end

    // Hold decoder state; update once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            count_reg   <= 8'sd0;
            pending_reg <= 1'b0;
            last_reg    <= 1'b0;
            long_reg    <= '0;
            short_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            pending_reg <= pending_next;
            last_reg    <= last_next;
            long_reg    <= long_next;
            short_reg   <= short_next;
        end
    end

endmodule

@@ tb/rebd_checker.sv @@
// Scoreboard for the rotary encoder and button decoder: predicts every result from
// the accepted item transactions and compares it field by field. Depends on rebd_pkg, rebd_if.
`timescale 1ns / 1ps

module rebd_checker
    import rebd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    rebd_item_if                   item_ch,
    rebd_result_if                 result_ch,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output int                     fail_count,
    output int                     pending
);

    // Phase tracker codes
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_HI_HALF = 3'd1;
    localparam logic [2:0] PH_LO_HALF = 3'd2;
    localparam logic [2:0] PH_BOTH_LO = 3'd3;
    localparam logic [2:0] PH_BROKEN  = 3'd5;

    // Shadow configuration
    logic [MS_W-1:0]  cfg_debounce;
    logic [MS_W-1:0]  cfg_long;
    logic             cfg_invert;

    // Shadow decoder state
    logic [2:0]        phase;
    logic signed [7:0] detents;
    logic              press_flag;
    logic              was_pressed;
    logic [NOW_W-1:0]  long_dl;
    logic [NOW_W-1:0]  short_dl;

    result_t awaited_results[$];

    assign pending = awaited_results.size();

    // Advance the shadow decoder by one item and return the result it causes
    function automatic result_t decode_item(input item_t it);
        result_t    r;
        logic       lo;
        logic       hi;
        logic       pressed;
        logic [2:0] prev_phase;
        r.event_code = EV_NONE;
        r.beep       = 1'b0;
        r.soft_reset = 1'b0;
        if (it.operation == OP_POLL)
        begin
            if (press_flag)
            begin
                press_flag   = 1'b0;
                r.event_code = EV_SELECT;
            end
            else if (detents > 8'sd0)
            begin
                detents      = 8'sd0;
                r.event_code = EV_NEXT;
            end
            else if (detents < 8'sd0)
            begin
                detents      = 8'sd0;
                r.event_code = EV_PREV;
            end
        end
        else
        begin
            lo         = cfg_invert ? it.enc_b : it.enc_a;
            hi         = cfg_invert ? it.enc_a : it.enc_b;
            prev_phase = phase;
            if (lo && hi)
                phase = PH_IDLE;
            else if (hi)
                phase = (prev_phase == PH_IDLE || prev_phase == PH_HI_HALF) ? PH_HI_HALF
                                                                           : PH_BROKEN;
            else if (lo)
                phase = (prev_phase == PH_IDLE || prev_phase == PH_LO_HALF) ? PH_LO_HALF
                                                                           : PH_BROKEN;
            else
            begin
                // Both pins low completes a detent from a clean half step
                if (prev_phase == PH_HI_HALF && detents < CNT_MAX)
                    detents = detents + 8'sd1;
                if (prev_phase == PH_LO_HALF && detents > CNT_MIN)
                    detents = detents - 8'sd1;
                phase = PH_BOTH_LO;
            end

            pressed = ~it.button_raw;
            r.beep  = pressed;
            if (pressed)
            begin
                if (long_dl != '0 && long_dl < it.now_ms)
                begin
                    r.soft_reset = 1'b1;
                    long_dl      = '0;
                end
            end
            else
                long_dl = '0;

            // Button edge: arm the long-press deadline, debounce new presses
            if (pressed != was_pressed)
            begin
                if (pressed)
                    long_dl = it.now_ms + NOW_W'(cfg_long);
                was_pressed = pressed;
                if (pressed && short_dl < it.now_ms)
                begin
                    short_dl   = it.now_ms + NOW_W'(cfg_debounce);
                    press_flag = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Track configuration, predict on each item transaction, compare on each result
    always @(posedge clk or negedge rst_n)
    begin
        item_t   it;
        result_t want;
        if (!rst_n)
        begin
            cfg_debounce = DEBOUNCE_MS_RST;
            cfg_long     = LONG_PRESS_MS_RST;
            cfg_invert   = 1'b0;
            phase        = PH_IDLE;
            detents      = 8'sd0;
            press_flag   = 1'b0;
            was_pressed  = 1'b0;
            long_dl      = '0;
            short_dl     = '0;
            fail_count   = 0;
            awaited_results.delete();
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (result_ch.event_code !== want.event_code)
                    begin
                        $error("event_code expected %0d actual %0d",
                               want.event_code, result_ch.event_code);
                        fail_count = fail_count + 1;
                    end
                    if (result_ch.beep !== want.beep)
                    begin
                        $error("beep expected %0b actual %0b", want.beep, result_ch.beep);
                        fail_count = fail_count + 1;
                    end
                    if (result_ch.soft_reset !== want.soft_reset)
                    begin
                        $error("soft_reset expected %0b actual %0b",
                               want.soft_reset, result_ch.soft_reset);
                        fail_count = fail_count + 1;
                    end
                end
            end

            if (item_ch.valid && item_ch.ready)
            begin
                it.operation  = item_ch.operation;
                it.enc_a      = item_ch.enc_a;
                it.enc_b      = item_ch.enc_b;
                it.button_raw = item_ch.button_raw;
                it.now_ms     = item_ch.now_ms;
                awaited_results.push_back(decode_item(it));
            end

            if (wr_en)
            begin
                case (wr_index)
                    REG_DEBOUNCE:   cfg_debounce = wr_data;
                    REG_LONG_PRESS: cfg_long     = wr_data;
                    REG_INVERT:     cfg_invert   = wr_data[0];
                    default:        ;
                endcase
            end
        end
    end

endmodule

@@ tb/tb_rotary_encoder_button_decoder_top.sv @@
// Testbench top for the rotary encoder and button decoder: clock, reset, stimulus,
// configuration phases and verdict. Depends on rebd_pkg, rebd_if, rebd_checker and the block.
`timescale 1ns / 1ps

module tb_rotary_encoder_button_decoder_top;
    import rebd_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int ITEMS_PER_PHASE  = 8;
    localparam int DETENTS_TO_LIMIT = 128;

    logic                   clk;
    logic                   rst_n;
    logic                   wr_en;
    logic [CFG_INDEX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0]  wr_data;
    int                     fail_count;
    int                     pending;

    // Stimulus bookkeeping
    logic [NOW_W-1:0] cur_time;
    logic             cur_a;
    logic             cur_b;
    logic             btn_level;
    logic [MS_W-1:0]  cfg_debounce;
    logic [MS_W-1:0]  cfg_long;
    bit               src_gaps;
    bit               sink_gaps;
    bit               hold_req;
    bit               drained;
    int               sent;

    rebd_item_if   item_ch();
    rebd_result_if result_ch();

    rotary_encoder_button_decoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    rebd_checker scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_ch    (item_ch),
        .result_ch  (result_ch),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Free-running clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Hard stop for a hung run
    initial
    begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int draw_wait(input bit gaps);
        return gaps ? $urandom_range(0, 19) : 0;
    endfunction

    // Offer one item transaction and hold it until taken
    task automatic send_item(input item_t it);
        int gap;
        gap = draw_wait(src_gaps);
        @(negedge clk);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.operation  <= it.operation;
        item_ch.enc_a      <= it.enc_a;
        item_ch.enc_b      <= it.enc_b;
        item_ch.button_raw <= it.button_raw;
        item_ch.now_ms     <= it.now_ms;
        item_ch.valid      <= 1'b1;
        do @(posedge clk); while (!item_ch.ready);
        sent++;
    endtask

    task automatic sample(input logic a, input logic b, input logic btn,
                          input logic [NOW_W-1:0] now);
        item_t it;
        it.operation  = OP_SAMPLE;
        it.enc_a      = a;
        it.enc_b      = b;
        it.button_raw = btn;
        it.now_ms     = now;
        cur_a         = a;
        cur_b         = b;
        btn_level     = btn;
        cur_time      = now;
        send_item(it);
    endtask

    // Poll with junk on the fields it ignores
    task automatic poll();
        item_t it;
        it.operation  = OP_POLL;
        it.enc_a      = 1'($urandom_range(0, 1));
        it.enc_b      = 1'($urandom_range(0, 1));
        it.button_raw = 1'($urandom_range(0, 1));
        it.now_ms     = $urandom;
        send_item(it);
    endtask

    // Step the pins with the button held where it is
    task automatic pins(input logic a, input logic b);
        sample(a, b, btn_level, cur_time + $urandom_range(0, 40));
    endtask

    // Drop valid once the current burst is done
    task automatic end_burst();
        @(negedge clk);
        item_ch.valid <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(negedge clk);
        wr_en    <= 1'b0;
    endtask

    // Wait for the block to drain, then write every register
    task automatic set_config(input logic [MS_W-1:0] deb, input logic [MS_W-1:0] lng,
                              input logic inv);
        logic [31:0] junk;
        junk = $urandom;
        end_burst();
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_LONG_PRESS, lng);
        write_reg(REG_INVERT, {junk[14:0], inv});
        write_reg(REG_SPARE, junk[31:16]);
        cfg_debounce = deb;
        cfg_long     = lng;
    endtask

    // One clean detent per repeat, both pins high to start
    task automatic spin(input bit cw, input int count);
        repeat (count)
        begin
            if (cw)
                pins(1'b0, 1'b1);
            else
                pins(1'b1, 1'b0);
            pins(1'b0, 1'b0);
            pins(1'b1, 1'b1);
        end
    endtask

    // Detent in a random direction, now and then broken or stuttering
    task automatic detent_segment();
        bit cw;
        int flaw;
        cw   = $urandom_range(0, 1);
        flaw = $urandom_range(0, 9);
        pins(1'b1, 1'b1);
        if (cw)
            pins(1'b0, 1'b1);
        else
            pins(1'b1, 1'b0);
        if (flaw == 0)
        begin
            if (cw)
                pins(1'b1, 1'b0);
            else
                pins(1'b0, 1'b1);
        end
        else if (flaw == 1)
            pins(cur_a, cur_b);
        pins(1'b0, 1'b0);
        if (flaw == 2)
            pins(1'b0, 1'b0);
        pins(1'b1, 1'b1);
    endtask

    // Press, hold around the long-press deadline, release, maybe bounce
    task automatic press_segment();
        logic [NOW_W-1:0] t0;
        logic [NOW_W-1:0] hold;
        int               steps;
        case ($urandom_range(0, 5))
            0: hold = NOW_W'(cfg_long);
            1: hold = NOW_W'(cfg_long) + 1;
            2: hold = NOW_W'(cfg_long) + 2;
            3: hold = (cfg_long > 0) ? NOW_W'(cfg_long) - 1 : '0;
            4: hold = $urandom_range(0, cfg_long);
            default: hold = NOW_W'(cfg_long) * 2 + $urandom_range(0, 50);
        endcase
        if ($urandom_range(0, 3) == 0)
            t0 = cur_time + $urandom_range(0, 20);
        else
            t0 = cur_time + NOW_W'(cfg_debounce) + $urandom_range(0, 2);
        sample(cur_a, cur_b, 1'b0, t0);
        steps = $urandom_range(0, 3);
        repeat (steps) sample(cur_a, cur_b, 1'b0, t0 + $urandom_range(0, hold));
        sample(cur_a, cur_b, 1'b0, t0 + hold);
        if ($urandom_range(0, 1) == 1)
            sample(cur_a, cur_b, 1'b0, t0 + hold);
        sample(cur_a, cur_b, 1'b1, t0 + hold + $urandom_range(0, 5));
        // Bounce: re-press near the debounce boundary
        if ($urandom_range(0, 2) == 0)
        begin
            sample(cur_a, cur_b, 1'b0,
                   t0 + NOW_W'(cfg_debounce) + $urandom_range(0, 2) - 1);
            sample(cur_a, cur_b, 1'b1, cur_time + $urandom_range(0, 3));
        end
    endtask

    task automatic random_segment();
        int          pick;
        item_t       it;
        logic [63:0] raw;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            detent_segment();
        else if (pick < 55)
            press_segment();
        else if (pick < 75)
        begin
            poll();
            if ($urandom_range(0, 1) == 1)
                poll();
        end
        else if (pick < 85)
            sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), $urandom);
        else if (pick < 92)
        begin
            // Jump the clock, often close to the wrap point
            if ($urandom_range(0, 1) == 1)
                cur_time = $urandom;
            else
                cur_time = 32'hFFFF_FFFF - $urandom_range(0, cfg_long + 100);
            pins(cur_a, cur_b);
        end
        else
        begin
            raw       = {$urandom, $urandom};
            it        = item_t'(raw[$bits(item_t)-1:0]);
            btn_level = it.button_raw;
            send_item(it);
        end
    endtask

    task automatic random_phase();
        int start;
        start = sent;
        while (sent - start < ITEMS_PER_PHASE) random_segment();
    endtask

    // Result side: random stalls, one long hold-off on request
    initial
    begin : result_drain
        int wait_cycles;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req    = 1'b0;
                wait_cycles = HOLD_OFF_CYCLES;
            end
            else
                wait_cycles = draw_wait(sink_gaps);
            if (wait_cycles > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    // Main sequence
    initial
    begin : stimulus
        int settle;
        rst_n              = 1'b0;
        wr_en              = 1'b0;
        wr_index           = '0;
        wr_data            = '0;
        item_ch.valid      = 1'b0;
        item_ch.operation  = OP_SAMPLE;
        item_ch.enc_a      = 1'b1;
        item_ch.enc_b      = 1'b1;
        item_ch.button_raw = 1'b1;
        item_ch.now_ms     = '0;
        cur_time           = '0;
        cur_a              = 1'b1;
        cur_b              = 1'b1;
        btn_level          = 1'b1;
        cfg_debounce       = DEBOUNCE_MS_RST;
        cfg_long           = LONG_PRESS_MS_RST;
        src_gaps           = 1'b1;
        sink_gaps          = 1'b1;
        hold_req           = 1'b0;
        drained            = 1'b0;
        sent               = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: rotation in both directions and a broken sequence
        poll();
        sample(1'b1, 1'b1, 1'b1, 32'd0);
        sample(1'b0, 1'b1, 1'b1, 32'd10);
        sample(1'b0, 1'b0, 1'b1, 32'd20);
        sample(1'b1, 1'b1, 1'b1, 32'd30);
        poll();
        sample(1'b1, 1'b0, 1'b1, 32'd40);
        sample(1'b0, 1'b0, 1'b1, 32'd50);
        sample(1'b1, 1'b1, 1'b1, 32'd60);
        poll();
        sample(1'b0, 1'b1, 1'b1, 32'd70);
        sample(1'b1, 1'b0, 1'b1, 32'd80);
        sample(1'b0, 1'b0, 1'b1, 32'd90);
        sample(1'b1, 1'b1, 1'b1, 32'd100);
        // Directed: press, long-press boundary, repeated and debounced presses
        sample(1'b1, 1'b1, 1'b0, 32'd1000);
        sample(1'b1, 1'b1, 1'b0, 32'd6000);
        sample(1'b1, 1'b1, 1'b0, 32'd6001);
        sample(1'b1, 1'b1, 1'b1, 32'd7100);
        sample(1'b1, 1'b1, 1'b0, 32'd7200);
        sample(1'b1, 1'b1, 1'b1, 32'd7250);
        sample(1'b1, 1'b1, 1'b0, 32'd7400);
        // Select outranks a pending detent, which survives the select poll
        spin(1'b1, 1);
        poll();
        poll();
        // Directed: deadline that wraps to zero, then one that wraps past now
        sample(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF - 32'd5000 + 32'd1);
        sample(1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF - 32'd5000 + 32'd1);
        sample(1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF);
        sample(1'b1, 1'b1, 1'b1, 32'hFFFF_FFF0);
        sample(1'b1, 1'b1, 1'b0, 32'hFFFF_FFF0);
        sample(1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF);
        sample(1'b1, 1'b1, 1'b1, 32'd0);
        poll();

        // Counter floor at -127, with a long result stall while items keep coming
        src_gaps  = 1'b0;
        sink_gaps = 1'b1;
        pins(1'b1, 1'b1);
        hold_req = 1'b1;
        spin(1'b0, DETENTS_TO_LIMIT);
        poll();

        // Random phases over several settings
        set_config(16'd0, 16'd0, 1'b1);
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        random_phase();

        set_config(16'hFFFF, 16'hFFFF, 1'b0);
        src_gaps  = 1'b0;
        sink_gaps = 1'b1;
        random_phase();

        set_config(16'd10, 16'd40, 1'b1);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        random_phase();

        set_config(16'($urandom_range(0, 300)), 16'($urandom_range(0, 2000)),
                   1'($urandom_range(0, 1)));
        src_gaps  = 1'b1;
        sink_gaps = 1'b0;
        random_phase();

        set_config(DEBOUNCE_MS_RST, LONG_PRESS_MS_RST, 1'b0);
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        random_phase();

        // Drain and verdict
        end_burst();
        settle = 0;
        while (pending != 0 && settle < 4000)
        begin
            @(negedge clk);
            settle++;
        end
        drained = (pending == 0);
        if (!drained)
            $error("%0d expected results never arrived", pending);
        repeat (10) @(negedge clk);
        if (fail_count == 0 && drained)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
